### hdl/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_HEAD = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REVERSE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic exec;     // perform the request on the ports this cycle
    logic load_rd;  // capture the store read data into the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_pending;  // request is a remove that reads the store
  } dp_stat_t;

endpackage

### hdl/rdq_ctrl.sv
`timescale 1ns / 1ps

module rdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rdq_pkg::dp_stat_t stat,
  output rdq_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == S_READ);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;

  assign cmd.exec    = accept;
  assign cmd.load_rd = (state == S_READ);

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE, S_RESP: begin
        if (accept) begin
          state_next = stat.rd_pending ? S_READ : S_RESP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/rdq_datapath.sv
`timescale 1ns / 1ps

module rdq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  rdq_pkg::req_t     req,
  input  rdq_pkg::dp_cmd_t  cmd,
  output rdq_pkg::dp_stat_t stat,
  output rdq_pkg::rsp_t     rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [rdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rdq_pkg::DATA_W-1:0] mem_q;

  logic [AW-1:0] front;
  logic [AW-1:0] back;
  logic [CW-1:0] cnt;
  logic          reversed;

  logic [AW-1:0] front_next;
  logic [AW-1:0] back_next;
  logic [CW-1:0] cnt_next;
  logic          reversed_next;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] back_dec;
  logic [AW-1:0] back_inc;

  logic                          at_front;
  logic                          is_full;
  logic                          is_empty;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_pending;
  logic [rdq_pkg::STATUS_W-1:0]  status;
  logic [CW+rdq_pkg::COUNT_W-1:0] cnt_ext;

  assign front_dec = (front == '0) ? LAST_IDX : front - AW'(1);
  assign front_inc = (front == LAST_IDX) ? '0 : front + AW'(1);
  assign back_dec  = (back == '0) ? LAST_IDX : back - AW'(1);
  assign back_inc  = (back == LAST_IDX) ? '0 : back + AW'(1);

  assign is_full  = (cnt == FULL_CNT);
  assign is_empty = (cnt == '0);
  assign at_front = (req.func == rdq_pkg::FN_INS_HEAD) ? !reversed : reversed;

  always_comb begin
    front_next    = front;
    back_next     = back;
    cnt_next      = cnt;
    reversed_next = reversed;
    wr_en         = 1'b0;
    wr_addr       = back;
    rd_addr       = reversed ? back_dec : front;
    rd_pending    = 1'b0;
    status        = rdq_pkg::ST_OK;
    case (req.func) inside
      rdq_pkg::FN_INS_HEAD, rdq_pkg::FN_INS_TAIL: begin
        if (is_full) begin
          status = rdq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
          if (at_front) begin
            front_next = front_dec;
            wr_addr    = front_dec;
          end else begin
            back_next = back_inc;
            wr_addr   = back;
          end
        end
      end
      rdq_pkg::FN_REM_HEAD: begin
        if (is_empty) begin
          status = rdq_pkg::ST_EMPTY;
        end else begin
          rd_pending = 1'b1;
          cnt_next   = cnt - CW'(1);
          if (reversed) begin
            back_next = back_dec;
          end else begin
            front_next = front_inc;
          end
        end
      end
      rdq_pkg::FN_REVERSE: reversed_next = !reversed;
      rdq_pkg::FN_CLEAR: begin
        front_next    = '0;
        back_next     = '0;
        cnt_next      = '0;
        reversed_next = 1'b0;
      end
      default: ;
    endcase
  end

  assign stat.rd_pending = rd_pending;
  assign cnt_ext = {{rdq_pkg::COUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      back     <= '0;
      cnt      <= '0;
      reversed <= 1'b0;
    end else if (cmd.exec) begin
      front    <= front_next;
      back     <= back_next;
      cnt      <= cnt_next;
      reversed <= reversed_next;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (cmd.exec) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.status        <= status;
      rsp.removed_value <= '0;
      rsp.count         <= cnt_ext[rdq_pkg::COUNT_W-1:0];
    end else if (cmd.load_rd) begin
      rsp.removed_value <= mem_q;
    end
  end

endmodule

### hdl/reversible_deque.sv
// reversible deque: bounded double-ended queue of signed 32-bit values
// done follows acceptance in the next cycle; a successful remove first waits in S_READ
// throughput: one request per cycle while busy is low; a successful remove raises busy
// the wait state comes from the registered read port of the store
// reset: synchronous active-high rst empties the queue and clears the reverse flag
// the receiver cannot stall; each result is shown for exactly one cycle
`timescale 1ns / 1ps

module reversible_deque #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rdq_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output rdq_pkg::rsp_t rsp
);

  // command and status between controller and datapath
  rdq_pkg::dp_cmd_t  cmd;
  rdq_pkg::dp_stat_t stat;

  // controller: accepts a transfer when start is high and busy low,
  // inserts a read wait state for a successful remove, then strobes done
  rdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: circular store, head and tail pointers, count and
  // reverse flag; reversal swaps which end counts as the head
  rdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

### hdl/rdq_checker.sv
`timescale 1ns / 1ps

module rdq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input rdq_pkg::req_t req,
  input logic          busy,
  input logic          done,
  input rdq_pkg::rsp_t rsp
);

  // every accepted transfer yields a strobe or a wait cycle next
  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted transfer produced no response");

  // a wait cycle is always followed by the result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("wait cycle not followed by result");

  // refused operations never return a value
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != rdq_pkg::ST_OK |-> rsp.removed_value == '0)
    else $error("refused operation returned a value");

  // a clear reports an empty queue without a wait state
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.func == rdq_pkg::FN_CLEAR |=>
      done && rsp.count == '0 && rsp.status == rdq_pkg::ST_OK)
    else $error("clear did not report empty queue");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

### tb/reversible_deque_test.sv
`timescale 1ns / 1ps

module reversible_deque_test;

  localparam int DEPTH = 64;

  typedef logic [rdq_pkg::FUNC_W-1:0] func_t;

  // func codes the block must ignore
  localparam func_t FN_SPARE_5 = 3'd5;
  localparam func_t FN_SPARE_6 = 3'd6;
  localparam func_t FN_SPARE_7 = 3'd7;

  localparam int RAND_ITEMS = 650;

  // fill drives the queue up to full, drain takes it down to empty
  typedef enum logic [2:0] {
    MODE_FILL  = 3'b001,
    MODE_DRAIN = 3'b010,
    MODE_NOISE = 3'b100
  } mode_t;

  logic          clk;
  logic          rst;
  logic          start;
  rdq_pkg::req_t req;
  logic          busy;
  logic          done;
  rdq_pkg::rsp_t rsp;

  // expectation pinned by a directed row, travels with the request
  logic          pin_use;
  rdq_pkg::rsp_t pin_rsp;

  reversible_deque #(.DEPTH(DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // deque predictor: its own store, pointers, count and reverse flag
  // ---------------------------------------------------------------
  logic [rdq_pkg::DATA_W-1:0]  dq_mem [DEPTH];
  logic [5:0]                  dq_front = '0;  // slot of the first element
  logic [5:0]                  dq_back  = '0;  // slot one past the last element
  logic [rdq_pkg::COUNT_W-1:0] dq_cnt   = '0;
  logic                        dq_rev   = 1'b0;

  // apply one request to the predictor and return the result it gives
  function automatic rdq_pkg::rsp_t deque_apply(input rdq_pkg::req_t r);
    rdq_pkg::rsp_t o;
    logic at_front;
    o = '0;
    case (r.func) inside
      rdq_pkg::FN_INS_HEAD, rdq_pkg::FN_INS_TAIL: begin
        if (dq_cnt >= DEPTH) begin
          o.status = rdq_pkg::ST_FULL;
        end else begin
          // logical head sits at the physical back while reversed
          at_front = (r.func == rdq_pkg::FN_INS_HEAD) ^ dq_rev;
          if (at_front) begin
            dq_front = dq_front - 1'b1;
            dq_mem[dq_front] = r.value;
          end else begin
            dq_mem[dq_back] = r.value;
            dq_back = dq_back + 1'b1;
          end
          dq_cnt = dq_cnt + 1'b1;
        end
      end
      rdq_pkg::FN_REM_HEAD: begin
        if (dq_cnt == 0) begin
          o.status = rdq_pkg::ST_EMPTY;
        end else begin
          if (!dq_rev) begin
            o.removed_value = dq_mem[dq_front];
            dq_front = dq_front + 1'b1;
          end else begin
            dq_back = dq_back - 1'b1;
            o.removed_value = dq_mem[dq_back];
          end
          dq_cnt = dq_cnt - 1'b1;
        end
      end
      rdq_pkg::FN_REVERSE: dq_rev = ~dq_rev;
      rdq_pkg::FN_CLEAR: begin
        dq_front = '0;
        dq_back  = '0;
        dq_cnt   = '0;
        dq_rev   = 1'b0;
      end
      default: ;  // spare codes leave everything alone
    endcase
    o.count = dq_cnt;
    return o;
  endfunction

  // ---------------------------------------------------------------
  // monitor: predicts on each request transfer, checks each result
  // ---------------------------------------------------------------
  rdq_pkg::rsp_t expected_rsp [$];
  int   err_cnt     = 0;
  int   n_accepted  = 0;
  int   n_results   = 0;
  int   n_full      = 0;
  int   n_empty     = 0;
  int   n_reverse   = 0;
  int   n_spare     = 0;
  int   peak_cnt    = 0;

  always @(posedge clk) begin : monitor
    rdq_pkg::rsp_t pred;
    rdq_pkg::rsp_t want;
    if (!rst) begin
      // request transfer: start high while busy low at this edge
      if (start && !busy) begin
        pred = deque_apply(req);
        expected_rsp.push_back(pin_use ? pin_rsp : pred);
        n_accepted++;
        if (pred.status == rdq_pkg::ST_FULL) n_full++;
        if (pred.status == rdq_pkg::ST_EMPTY) n_empty++;
        if (req.func == rdq_pkg::FN_REVERSE) n_reverse++;
        if (req.func > rdq_pkg::FN_CLEAR) n_spare++;
        if (pred.count > peak_cnt) peak_cnt = pred.count;
      end
      // result transfer: done is a one-cycle strobe, no back pressure
      if (done) begin
        n_results++;
        if (expected_rsp.size() == 0) begin
          $error("result with nothing outstanding: status %0d value %0d count %0d",
                 rsp.status, rsp.removed_value, rsp.count);
          err_cnt++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_cnt++;
          end
          if (rsp.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, rsp.removed_value);
            err_cnt++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------

  // occupancy as seen by the sender, used only to steer the random part
  int level = 0;

  // present one request and hold it until the transfer edge;
  // start is left high so a following request goes back to back
  task automatic issue(input rdq_pkg::req_t r, input logic pin, input rdq_pkg::rsp_t pr);
    start   <= 1'b1;
    req     <= r;
    pin_use <= pin;
    pin_rsp <= pr;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (r.func) inside
      rdq_pkg::FN_INS_HEAD, rdq_pkg::FN_INS_TAIL: if (level < DEPTH) level++;
      rdq_pkg::FN_REM_HEAD:                       if (level > 0) level--;
      rdq_pkg::FN_CLEAR:                          level = 0;
      default: ;
    endcase
  endtask

  // directed table: pinned rows carry a result readable at a glance
  typedef struct {
    func_t                        func;
    logic [rdq_pkg::DATA_W-1:0]   value;
    logic                         pin;
    logic [rdq_pkg::STATUS_W-1:0] st;
    logic [rdq_pkg::DATA_W-1:0]   rv;
    logic [rdq_pkg::COUNT_W-1:0]  cnt;
  } dir_row_t;

  dir_row_t dir_tbl [$];

  task automatic add_row(input func_t f, input logic [rdq_pkg::DATA_W-1:0] v,
                         input logic p, input logic [rdq_pkg::STATUS_W-1:0] s,
                         input logic [rdq_pkg::DATA_W-1:0] rv,
                         input logic [rdq_pkg::COUNT_W-1:0] c);
    dir_row_t row;
    row.func = f; row.value = v; row.pin = p;
    row.st = s; row.rv = rv; row.cnt = c;
    dir_tbl.push_back(row);
  endtask

  function automatic logic [rdq_pkg::DATA_W-1:0] pick_value();
    logic [rdq_pkg::DATA_W-1:0] v;
    v = $urandom;
    // lean on the extremes now and then
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'h0000_0000;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'h8000_0000;
        default: v = 32'h7FFF_FFFF;
      endcase
    end
    return v;
  endfunction

  function automatic func_t pick_insert();
    return $urandom_range(0, 1) ? rdq_pkg::FN_INS_HEAD : rdq_pkg::FN_INS_TAIL;
  endfunction

  function automatic func_t pick_spare();
    return func_t'(rdq_pkg::FN_CLEAR + $urandom_range(1, 3));
  endfunction

  initial begin : stimulus
    rdq_pkg::req_t r;
    rdq_pkg::rsp_t pr;
    mode_t         mode;
    int            burst_left;
    int            extra;
    int            pick;

    rst     <= 1'b1;
    start   <= 1'b0;
    req     <= '0;
    pin_use <= 1'b0;
    pin_rsp <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // remove and reverse on an empty queue, then extremes both ends
    add_row(rdq_pkg::FN_REM_HEAD, 32'h1234_5678, 1, rdq_pkg::ST_EMPTY, 0, 0);
    add_row(rdq_pkg::FN_REVERSE,  32'hFFFF_FFFF, 1, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REVERSE,  32'h0,         1, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_INS_HEAD, 32'h7FFF_FFFF, 1, rdq_pkg::ST_OK,    0, 1);
    add_row(rdq_pkg::FN_INS_TAIL, 32'h8000_0000, 1, rdq_pkg::ST_OK,    0, 2);
    add_row(rdq_pkg::FN_INS_HEAD, 32'hFFFF_FFFF, 1, rdq_pkg::ST_OK,    0, 3);
    add_row(rdq_pkg::FN_INS_TAIL, 32'h0,         1, rdq_pkg::ST_OK,    0, 4);
    // spare codes change nothing, even with a value attached
    add_row(FN_SPARE_5,           32'hDEAD_BEEF, 1, rdq_pkg::ST_OK,    0, 4);
    add_row(FN_SPARE_6,           32'h0,         1, rdq_pkg::ST_OK,    0, 4);
    add_row(FN_SPARE_7,           32'hFFFF_FFFF, 1, rdq_pkg::ST_OK,    0, 4);
    // head holds the last head insert
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         1, rdq_pkg::ST_OK,    32'hFFFF_FFFF, 3);
    add_row(rdq_pkg::FN_REVERSE,  32'h0,         1, rdq_pkg::ST_OK,    0, 3);
    // reversed: head is now the tail end
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         1, rdq_pkg::ST_OK,    32'h0, 2);
    add_row(rdq_pkg::FN_INS_HEAD, 32'h1234_5678, 0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_INS_TAIL, 32'h5A5A_5A5A, 0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REVERSE,  32'h0,         0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         0, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REVERSE,  32'h0,         0, rdq_pkg::ST_OK,    0, 0);
    // clear while reversed and non-empty, then nothing left to remove
    add_row(rdq_pkg::FN_CLEAR,    32'hFFFF_FFFF, 1, rdq_pkg::ST_OK,    0, 0);
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         1, rdq_pkg::ST_EMPTY, 0, 0);
    add_row(rdq_pkg::FN_INS_TAIL, 32'hA5A5_A5A5, 1, rdq_pkg::ST_OK,    0, 1);
    add_row(rdq_pkg::FN_REM_HEAD, 32'h0,         1, rdq_pkg::ST_OK,    32'hA5A5_A5A5, 0);

    foreach (dir_tbl[i]) begin
      r.func  = dir_tbl[i].func;
      r.value = dir_tbl[i].value;
      pr.status        = dir_tbl[i].st;
      pr.removed_value = dir_tbl[i].rv;
      pr.count         = dir_tbl[i].cnt;
      issue(r, dir_tbl[i].pin, pr);
    end

    // random part: fill to full, drain to empty, with reversals mixed
    // in; a short stretch of pure noise in the middle
    mode       = MODE_FILL;
    extra      = $urandom_range(1, 4);
    burst_left = $urandom_range(1, 24);
    pr         = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick    = $urandom_range(0, 99);
      r.value = pick_value();
      case (mode)
        MODE_FILL: begin
          if (pick < 72)      r.func = pick_insert();
          else if (pick < 84) r.func = rdq_pkg::FN_REM_HEAD;
          else if (pick < 94) r.func = rdq_pkg::FN_REVERSE;
          else if (pick < 99) r.func = pick_spare();
          else                r.func = rdq_pkg::FN_CLEAR;
        end
        MODE_DRAIN: begin
          if (pick < 72)      r.func = rdq_pkg::FN_REM_HEAD;
          else if (pick < 84) r.func = pick_insert();
          else if (pick < 95) r.func = rdq_pkg::FN_REVERSE;
          else                r.func = pick_spare();
        end
        default: r.func = func_t'($urandom_range(0, 7));
      endcase
      issue(r, 1'b0, pr);

      // steer between phases; a few refused requests at each end
      if (mode == MODE_FILL && level == DEPTH) begin
        if (extra == 0) begin
          mode  = MODE_DRAIN;
          extra = $urandom_range(1, 4);
        end else if (r.func == rdq_pkg::FN_INS_HEAD || r.func == rdq_pkg::FN_INS_TAIL) begin
          extra--;
        end
      end else if (mode == MODE_DRAIN && level == 0) begin
        if (extra == 0) begin
          mode  = (n > 250 && n < 330) ? MODE_NOISE : MODE_FILL;
          extra = $urandom_range(1, 4);
        end else if (r.func == rdq_pkg::FN_REM_HEAD) begin
          extra--;
        end
      end else if (mode == MODE_NOISE && $urandom_range(0, 29) == 0) begin
        mode = MODE_FILL;
      end

      // halfway through, let every result drain before going on
      if (n == RAND_ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0) @(posedge clk);
      end else if (--burst_left == 0) begin
        // burst over: idle a while, sometimes a long gapless stretch next
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
      end
    end

    // wind down: all results in, then a few cycles for anything stray
    start <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests, %0d results: %0d full, %0d empty refusals",
             n_accepted, n_results, n_full, n_empty);
    $display("  %0d reversals, %0d spare codes, peak occupancy %0d",
             n_reverse, n_spare, peak_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #500_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
